// ===== rtl/core/rlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared defaults and the neighbor link type of the running median chain.
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int MAX_ITEMS_DEF   = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  // What a cell shows its neighbors besides its value.
  // le: stored value <= incoming sample; an empty cell reads as -inf below
  // the center and +inf at or above it, which keeps the row monotone.
  typedef struct packed {
    logic valid;
    logic le;
  } link_t;

endpackage

// ===== rtl/core/rlm_cell.sv =====
// ----------------------------------------------------------------------------
// rlm_cell
// One slot of the sorted row: holds a value, picks its next value from
// itself, a neighbor or the incoming sample.
// ----------------------------------------------------------------------------
module rlm_cell #(
  parameter int W        = rlm_pkg::VALUE_WIDTH_DEF,
  parameter bit LOW_SIDE = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [W-1:0]   v,
  input  logic           ins,
  input  logic           clr,
  input  logic           shift,
  input  rlm_pkg::link_t dn_link,
  input  logic [W-1:0]   dn_value,
  input  rlm_pkg::link_t up_link,
  input  logic [W-1:0]   up_value,
  output rlm_pkg::link_t link,
  output logic [W-1:0]   value,
  output logic [W-1:0]   value_next
);

  logic           occupied;
  logic           own_valid;
  rlm_pkg::link_t hi_link;
  rlm_pkg::link_t lo_link;
  logic [W-1:0]   hi_value;
  logic [W-1:0]   lo_value;
  logic [W-1:0]   sel_value;
  logic           sel_valid;

  assign own_valid = occupied & ~clr;
  assign link.valid = own_valid;
  assign link.le    = own_valid ? ($signed(value) <= $signed(v)) : LOW_SIDE;

  // shift: the whole row moves down one slot so the median stays centered
  assign hi_link  = shift ? up_link  : link;
  assign hi_value = shift ? up_value : value;
  assign lo_link  = shift ? link     : dn_link;
  assign lo_value = shift ? value    : dn_value;

  always_comb begin
    if (hi_link.le) begin
      sel_value = hi_value;
      sel_valid = hi_link.valid;
    end else if (!lo_link.le) begin
      sel_value = lo_value;
      sel_valid = lo_link.valid;
    end else begin
      sel_value = v;
      sel_valid = 1'b1;
    end
  end

  assign value_next = ins ? sel_value : value;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (ins) begin
      occupied <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      value <= sel_value;
    end
  end

endmodule

// ===== rtl/core/rlm_chain.sv =====
// ----------------------------------------------------------------------------
// rlm_chain
// Row of MAX_ITEMS cells, sorted ascending, with the lower median pinned to
// the center cell.
// ----------------------------------------------------------------------------
module rlm_chain #(
  parameter int MAX_ITEMS   = rlm_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_WIDTH = rlm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] v,
  input  logic                   ins,
  input  logic                   clr,
  input  logic                   shift,
  output logic [VALUE_WIDTH-1:0] median_next
);

  localparam int CENTER = (MAX_ITEMS - 1) / 2;

  localparam rlm_pkg::link_t LOW_END  = '{valid: 1'b0, le: 1'b1};
  localparam rlm_pkg::link_t HIGH_END = '{valid: 1'b0, le: 1'b0};

  rlm_pkg::link_t         links [MAX_ITEMS];
  logic [VALUE_WIDTH-1:0] values [MAX_ITEMS];
  logic [VALUE_WIDTH-1:0] nexts [MAX_ITEMS];

  for (genvar x = 0; x < MAX_ITEMS; x++) begin : g_cell
    rlm_pkg::link_t         dn_l;
    rlm_pkg::link_t         up_l;
    logic [VALUE_WIDTH-1:0] dn_v;
    logic [VALUE_WIDTH-1:0] up_v;

    if (x == 0) begin : g_lo_end
      assign dn_l = LOW_END;
      assign dn_v = '0;
    end else begin : g_lo_nb
      assign dn_l = links[x-1];
      assign dn_v = values[x-1];
    end

    if (x == MAX_ITEMS - 1) begin : g_hi_end
      assign up_l = HIGH_END;
      assign up_v = '0;
    end else begin : g_hi_nb
      assign up_l = links[x+1];
      assign up_v = values[x+1];
    end

    rlm_cell #(
      .W        (VALUE_WIDTH),
      .LOW_SIDE (x < CENTER)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .v          (v),
      .ins        (ins),
      .clr        (clr),
      .shift      (shift),
      .dn_link    (dn_l),
      .dn_value   (dn_v),
      .up_link    (up_l),
      .up_value   (up_v),
      .link       (links[x]),
      .value      (values[x]),
      .value_next (nexts[x])
    );
  end

  assign median_next = nexts[CENTER];

endmodule

// ===== rtl/core/rlm_out_buf.sv =====
// ----------------------------------------------------------------------------
// rlm_out_buf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module rlm_out_buf #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  output logic          valid,
  output logic [DW-1:0] data,
  input  logic          stall
);

  logic          skid_valid;
  logic [DW-1:0] skid_data;
  logic          take;
  logic          load_main;
  logic          load_skid;

  assign take      = valid & ~stall;
  assign load_main = ~skid_valid & push & (~valid | take);
  assign load_skid = ~skid_valid & push & valid & ~take;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (load_skid) begin
        skid_valid <= 1'b1;
      end else begin
        valid <= 1'b1;
      end
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && take) begin
      data <= skid_data;
    end else if (load_main) begin
      data <= push_data;
    end
    if (load_skid) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== rtl/core/running_lower_median.sv =====
// ----------------------------------------------------------------------------
// running_lower_median
// Running lower median of a signed sample stream, kept in a sorted row of
// cells with the median held in the center cell.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------
//  sample   | sample_valid / sample_stall | sample, start_new
//  result   | result_valid / result_stall | median, stored_count, full_res
//
//  One beat per cycle while sample_stall is low, one result beat per sample
//  beat. Every cell compares against the sample in the same cycle and takes
//  its next value from itself, a neighbor or the sample, so the result is
//  registered at the edge that takes the sample, in the skid slot if a result waits.
//  Reset clears the occupancy bits and the count; cell values are not reset.
//  sample_stall rises only when both result slots are held; a waiting result
//  does not block the next sample.
//
module running_lower_median #(
  parameter int MAX_ITEMS   = rlm_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_WIDTH = rlm_pkg::VALUE_WIDTH_DEF,
  parameter int CW          = $clog2(MAX_ITEMS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic [VALUE_WIDTH-1:0] sample,
  input  logic                   start_new,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [VALUE_WIDTH-1:0] median,
  output logic [CW-1:0]          stored_count,
  output logic                   full_res
);

  localparam int DW = VALUE_WIDTH + CW + 1;

  logic                   accept;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [CW-1:0]          n_eff;
  logic                   is_full;
  logic                   ins;
  logic                   shift;
  logic [VALUE_WIDTH-1:0] median_next;
  logic [DW-1:0]          res_data;

  assign accept = sample_valid & ~sample_stall;

  // start_new empties the store before this sample goes in
  assign n_eff   = start_new ? '0 : count;
  assign is_full = (n_eff == CW'(MAX_ITEMS));
  assign ins     = accept & ~is_full;

  // Inserting into an even, nonempty store moves the lower median up one
  // rank; the row shifts down one slot to keep it in the center cell.
  assign shift = (n_eff != '0) & ~n_eff[0];

  assign count_next = is_full ? n_eff : n_eff + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  rlm_chain #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_chain (
    .clk         (clk),
    .rst         (rst),
    .v           (sample),
    .ins         (ins),
    .clr         (start_new),
    .shift       (shift),
    .median_next (median_next)
  );

  rlm_out_buf #(
    .DW (DW)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({median_next, count_next, is_full}),
    .full      (sample_stall),
    .valid     (result_valid),
    .data      (res_data),
    .stall     (result_stall)
  );

  assign median       = res_data[DW-1 -: VALUE_WIDTH];
  assign stored_count = res_data[CW:1];
  assign full_res     = res_data[0];

  // store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("stored count above capacity");

  // a start beat always leaves exactly one value stored
  a_start_one: assert property (@(posedge clk) disable iff (rst)
    accept && start_new |=> count == CW'(1))
    else $error("start beat did not restart the store");

  // a dropped sample is reported only with a full store
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && full_res |-> stored_count == CW'(MAX_ITEMS))
    else $error("full flag with store not full");

  // input is held off only while a result is waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid)
    else $error("input stalled with no result pending");

  // a sample beat into a store below capacity grows the count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !start_new && count != CW'(MAX_ITEMS) |=> count == $past(count) + CW'(1))
    else $error("count did not advance on insert");

endmodule
